FILE: hw/rtl/spmb_pkg.sv
// ----------------------------------------------------------------------------
// spmb_pkg: shared types and constants for the stepper position mover
// Direction codes, sequencer stages, field widths and register indexes.
// ----------------------------------------------------------------------------
package spmb_pkg;

    localparam int DELAY_BITS     = 16;
    localparam int COIL_BITS      = 4;
    localparam int BACKLASH_BITS  = 8;
    localparam int TABLE_BITS     = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_CNT_BITS = 2;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_BL_FIRST   = 3'd1,
        ST_BL_STEP    = 3'd2,
        ST_MAIN_FIRST = 3'd3,
        ST_WALK       = 3'd4
    } stage_t;

    localparam logic [CFG_INDEX_BITS-1:0] REG_POSITION_MIN  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POSITION_MAX  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BACKLASH      = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COIL_TABLE    = 2'd3;

endpackage

FILE: hw/rtl/spmb_front.sv
// ----------------------------------------------------------------------------
// spmb_front: input acceptance and command queue
// Takes stream words, splits them into move or tick items and holds them in
// a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module spmb_front #(
    parameter int POSITION_BITS = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [((POSITION_BITS+spmb_pkg::DELAY_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                             s_axis_tuser,
    output logic                             q_valid,
    input  logic                             q_ready,
    output logic                             q_move,
    output logic [POSITION_BITS-1:0]         q_target,
    output logic [spmb_pkg::DELAY_BITS-1:0]  q_delay
);

    localparam int ITEM_BITS = 1 + POSITION_BITS + spmb_pkg::DELAY_BITS;

    logic [ITEM_BITS-1:0]                    slot_reg [spmb_pkg::QUEUE_DEPTH];
    logic [spmb_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_reg;
    logic [spmb_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_next;
    logic [spmb_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_reg;
    logic [spmb_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_next;
    logic [spmb_pkg::QUEUE_CNT_BITS-1:0]     count_reg;
    logic [spmb_pkg::QUEUE_CNT_BITS-1:0]     count_next;
    logic                                    push;
    logic                                    pop;
    logic [ITEM_BITS-1:0]                    head;

    assign s_axis_tready = (count_reg != spmb_pkg::QUEUE_CNT_BITS'(spmb_pkg::QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign pop           = q_valid && q_ready;

    assign head     = slot_reg[rd_ptr_reg];
    assign q_move   = head[ITEM_BITS-1];
    assign q_target = head[spmb_pkg::DELAY_BITS +: POSITION_BITS];
    assign q_delay  = head[spmb_pkg::DELAY_BITS-1:0];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= {s_axis_tuser,
                                     s_axis_tdata[POSITION_BITS-1:0],
                                     s_axis_tdata[POSITION_BITS +: spmb_pkg::DELAY_BITS]};
        end
    end

endmodule

FILE: hw/rtl/spmb_back.sv
// ----------------------------------------------------------------------------
// spmb_back: move sequencer and result register
// Runs backlash take-up, walk and release, one queued item per cycle while the
// result register is free or being taken, and holds each result word until the
// output side takes it.
module spmb_back #(
    parameter int POSITION_BITS = 14,
    parameter int PHASE_COUNT   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  logic                                q_move,
    input  logic [POSITION_BITS-1:0]            q_target,
    input  logic [spmb_pkg::DELAY_BITS-1:0]     q_delay,
    input  logic [POSITION_BITS-1:0]            position_min,
    input  logic [POSITION_BITS-1:0]            position_max,
    input  logic [spmb_pkg::BACKLASH_BITS-1:0]  backlash_steps,
    input  logic [spmb_pkg::TABLE_BITS-1:0]     coil_table,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [spmb_pkg::COIL_BITS-1:0]      out_coils,
    output logic                                out_busy,
    output logic [POSITION_BITS-1:0]            out_position,
    output logic                                out_ignored
);

    localparam int POS_W      = POSITION_BITS + 1;
    localparam int PHASE_BITS = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
    localparam logic [PHASE_BITS-1:0] PHASE_LAST = PHASE_BITS'(PHASE_COUNT - 1);
    localparam logic [POS_W-1:0]      POS_RESET  = {1'b0, {POSITION_BITS{1'b1}}};

    logic [POS_W-1:0]                    pos_reg, pos_next;
    logic [PHASE_BITS-1:0]               phase_reg, phase_next;
    spmb_pkg::dir_t                      last_dir_reg, last_dir_next;
    spmb_pkg::dir_t                      dir_reg, dir_next;
    logic [POSITION_BITS-1:0]            target_reg, target_next;
    logic [spmb_pkg::DELAY_BITS-1:0]     hold_reg, hold_next;
    logic [spmb_pkg::DELAY_BITS-1:0]     held_reg, held_next;
    logic [spmb_pkg::BACKLASH_BITS-1:0]  bl_reg, bl_next;
    spmb_pkg::stage_t                    stage_reg, stage_next;
    logic                                limit_reg, limit_next;

    logic                                out_valid_reg;
    logic [spmb_pkg::COIL_BITS-1:0]      coils_reg, coils_next;
    logic                                busy_reg, busy_next;
    logic [POSITION_BITS-1:0]            opos_reg, opos_next;
    logic                                ignored_reg, ignored_next;

    logic                                pop;
    logic [POSITION_BITS-1:0]            clamp_tgt;
    logic [POS_W-1:0]                    clamp_ext;
    logic [POS_W-1:0]                    min_ext;
    logic [POS_W-1:0]                    max_ext;
    spmb_pkg::dir_t                      dir_new;
    logic                                limit_new;
    logic                                reversal;
    logic [POS_W-1:0]                    pos_fwd;
    logic [POS_W-1:0]                    pos_back;
    logic [PHASE_BITS-1:0]               phase_step;
    logic                                walk_ok;

    assign q_ready      = !out_valid_reg || out_ready;
    assign pop          = q_valid && q_ready;
    assign out_valid    = out_valid_reg;
    assign out_coils    = coils_reg;
    assign out_busy     = busy_reg;
    assign out_position = opos_reg;
    assign out_ignored  = ignored_reg;

    assign min_ext = {1'b0, position_min};
    assign max_ext = {1'b0, position_max};

    // clamp the requested target; the lower limit wins when the limits cross
    always_comb
    begin
        clamp_tgt = q_target;
        if (clamp_tgt > position_max)
        begin
            clamp_tgt = position_max;
        end
        if (clamp_tgt < position_min)
        begin
            clamp_tgt = position_min;
        end
    end

    assign clamp_ext = {1'b0, clamp_tgt};

    always_comb
    begin
        if (pos_reg < clamp_ext)
        begin
            dir_new = spmb_pkg::DIR_UP;
        end
        else if (pos_reg > clamp_ext)
        begin
            dir_new = spmb_pkg::DIR_DOWN;
        end
        else
        begin
            dir_new = spmb_pkg::DIR_NONE;
        end
    end

    assign limit_new = (pos_reg == max_ext) || (pos_reg == min_ext);
    assign reversal  = (dir_new == spmb_pkg::DIR_UP   && last_dir_reg == spmb_pkg::DIR_DOWN) ||
                       (dir_new == spmb_pkg::DIR_DOWN && last_dir_reg == spmb_pkg::DIR_UP);

    // one step of the current move, forward and back
    always_comb
    begin
        pos_fwd    = pos_reg;
        pos_back   = pos_reg;
        phase_step = phase_reg;
        case (dir_reg)
            spmb_pkg::DIR_UP:
            begin
                pos_fwd    = pos_reg + POS_W'(1);
                pos_back   = pos_reg - POS_W'(1);
                phase_step = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
            end
            spmb_pkg::DIR_DOWN:
            begin
                pos_fwd    = pos_reg - POS_W'(1);
                pos_back   = pos_reg + POS_W'(1);
                phase_step = (phase_reg == '0) ? PHASE_LAST : phase_reg - 1'b1;
            end
            default:
            begin
                pos_fwd    = pos_reg;
            end
        endcase
    end

    assign walk_ok = (dir_reg != spmb_pkg::DIR_NONE) && (pos_reg != {1'b0, target_reg}) &&
                     (pos_reg < max_ext) && (pos_reg > min_ext);

    // next state of the sequencer for the item at the queue head
    always_comb
    begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        last_dir_next = last_dir_reg;
        dir_next      = dir_reg;
        target_next   = target_reg;
        hold_next     = hold_reg;
        held_next     = held_reg;
        bl_next       = bl_reg;
        stage_next    = stage_reg;
        limit_next    = limit_reg;
        ignored_next  = 1'b0;

        if (q_move && stage_reg == spmb_pkg::ST_IDLE)
        begin
            target_next = clamp_tgt;
            dir_next    = dir_new;
            held_next   = (q_delay == '0) ? spmb_pkg::DELAY_BITS'(1) : q_delay;
            hold_next   = held_next;
            limit_next  = limit_new;
            if (dir_new != spmb_pkg::DIR_NONE)
            begin
                last_dir_next = dir_new;
            end
            if (reversal)
            begin
                bl_next    = backlash_steps;
                stage_next = spmb_pkg::ST_BL_FIRST;
            end
            else
            begin
                // starting on a limit: step off it before the walk
                if (limit_new && dir_new == spmb_pkg::DIR_UP)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                else if (limit_new && dir_new == spmb_pkg::DIR_DOWN)
                begin
                    pos_next = pos_reg - POS_W'(1);
                end
                stage_next = spmb_pkg::ST_MAIN_FIRST;
            end
        end
        else
        begin
            ignored_next = q_move;
            if (stage_reg != spmb_pkg::ST_IDLE)
            begin
                if (hold_reg > spmb_pkg::DELAY_BITS'(1))
                begin
                    hold_next = hold_reg - 1'b1;
                end
                else
                begin
                    hold_next = held_reg;
                    unique case (stage_reg) inside
                        spmb_pkg::ST_BL_FIRST, spmb_pkg::ST_BL_STEP:
                        begin
                            if (bl_reg != '0)
                            begin
                                phase_next = phase_step;
                                bl_next    = bl_reg - 1'b1;
                                stage_next = spmb_pkg::ST_BL_STEP;
                            end
                            else
                            begin
                                if (limit_reg)
                                begin
                                    pos_next = pos_fwd;
                                end
                                stage_next = spmb_pkg::ST_MAIN_FIRST;
                            end
                        end
                        default:
                        begin
                            if (walk_ok)
                            begin
                                phase_next = phase_step;
                                pos_next   = pos_fwd;
                                stage_next = spmb_pkg::ST_WALK;
                            end
                            else
                            begin
                                // undo the limit step-off and release
                                if (limit_reg)
                                begin
                                    pos_next = pos_back;
                                end
                                stage_next = spmb_pkg::ST_IDLE;
                                hold_next  = '0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // result word from the new state
    always_comb
    begin
        busy_next = (stage_next != spmb_pkg::ST_IDLE);
        coils_next = busy_next ? coil_table[spmb_pkg::COIL_BITS*phase_next +: spmb_pkg::COIL_BITS]
                               : '0;
        opos_next = pos_next[POSITION_BITS] ? {POSITION_BITS{1'b1}}
                                            : pos_next[POSITION_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_RESET;
            phase_reg     <= '0;
            last_dir_reg  <= spmb_pkg::DIR_NONE;
            dir_reg       <= spmb_pkg::DIR_NONE;
            target_reg    <= '0;
            hold_reg      <= '0;
            held_reg      <= '0;
            bl_reg        <= '0;
            stage_reg     <= spmb_pkg::ST_IDLE;
            limit_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pos_reg      <= pos_next;
                phase_reg    <= phase_next;
                last_dir_reg <= last_dir_next;
                dir_reg      <= dir_next;
                target_reg   <= target_next;
                hold_reg     <= hold_next;
                held_reg     <= held_next;
                bl_reg       <= bl_next;
                stage_reg    <= stage_next;
                limit_reg    <= limit_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            coils_reg   <= coils_next;
            busy_reg    <= busy_next;
            opos_reg    <= opos_next;
            ignored_reg <= ignored_next;
        end
    end

endmodule

FILE: hw/rtl/stepper_position_mover_backlash_top.sv
// ----------------------------------------------------------------------------
// stepper_position_mover_backlash_top: stepper mover with backlash take-up
// Stream front end, command queue, move sequencer and configuration registers.
// ----------------------------------------------------------------------------
// Each input word is one time unit: a tick (tuser 0) or a move request
// (tuser 1), and each yields exactly one result word. The block takes one
// word per clock while the command queue has room. Each input is written
// into the two-entry command queue; the sequencer, whose state update per
// item is a single clamp, compare and increment, then takes it from the queue
// head and loads the result register once that register is free. The queue
// keeps input flowing while a result waits on the output; input stalls only
// once the queue is full. Configuration writes are always ready and take
// effect at once; limit changes act on a running walk immediately.
module stepper_position_mover_backlash_top #(
    parameter int POSITION_BITS = 14,
    parameter int PHASE_COUNT   = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [spmb_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [spmb_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: target, step_delay, zero fill
    input  logic [((POSITION_BITS+spmb_pkg::DELAY_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: command
    input  logic                                   s_axis_tuser,
    // result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata: coils, busy_res, position, move_ignored, zero fill
    output logic [((spmb_pkg::COIL_BITS+POSITION_BITS+2+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OUT_BITS  = spmb_pkg::COIL_BITS + POSITION_BITS + 2;
    localparam int OUT_WIDTH = ((OUT_BITS + 7) / 8) * 8;

    logic [POSITION_BITS-1:0]            position_min_reg;
    logic [POSITION_BITS-1:0]            position_max_reg;
    logic [spmb_pkg::BACKLASH_BITS-1:0]  backlash_reg;
    logic [spmb_pkg::TABLE_BITS-1:0]     coil_table_reg;

    logic                                q_valid;
    logic                                q_ready;
    logic                                q_move;
    logic [POSITION_BITS-1:0]            q_target;
    logic [spmb_pkg::DELAY_BITS-1:0]     q_delay;

    logic [spmb_pkg::COIL_BITS-1:0]      out_coils;
    logic                                out_busy;
    logic [POSITION_BITS-1:0]            out_position;
    logic                                out_ignored;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_min_reg <= '0;
            position_max_reg <= '1;
            backlash_reg     <= '0;
            coil_table_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                spmb_pkg::REG_POSITION_MIN: position_min_reg <= cfg_data[POSITION_BITS-1:0];
                spmb_pkg::REG_POSITION_MAX: position_max_reg <= cfg_data[POSITION_BITS-1:0];
                spmb_pkg::REG_BACKLASH:
                    backlash_reg <= cfg_data[spmb_pkg::BACKLASH_BITS-1:0];
                spmb_pkg::REG_COIL_TABLE:
                    coil_table_reg <= cfg_data[spmb_pkg::TABLE_BITS-1:0];
                default:                    coil_table_reg   <= coil_table_reg;
            endcase
        end
    end

    spmb_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_move        (q_move),
        .q_target      (q_target),
        .q_delay       (q_delay)
    );

    spmb_back #(
        .POSITION_BITS (POSITION_BITS),
        .PHASE_COUNT   (PHASE_COUNT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_move         (q_move),
        .q_target       (q_target),
        .q_delay        (q_delay),
        .position_min   (position_min_reg),
        .position_max   (position_max_reg),
        .backlash_steps (backlash_reg),
        .coil_table     (coil_table_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_coils      (out_coils),
        .out_busy       (out_busy),
        .out_position   (out_position),
        .out_ignored    (out_ignored)
    );

    assign m_axis_tdata = OUT_WIDTH'({out_ignored, out_position, out_busy, out_coils});

    // a released motor drives no coil
    a_idle_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_busy) |-> (out_coils == '0))
        else $error("coils driven while not busy");

    // the sequencer takes the queue head whenever the result register is free
    a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> q_ready)
        else $error("sequencer stalled with empty result register");

    // the queue fills only behind a stalled result word
    a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");

endmodule

FILE: bench/stepper_position_mover_backlash_top_test.sv
// ----------------------------------------------------------------------------
// stepper_position_mover_backlash_top_test: stream-level check of the mover
// Drives ticks and move requests, predicts every status word from a local
// model of the sequencer, and compares each returned word field by field.
// ----------------------------------------------------------------------------
module stepper_position_mover_backlash_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_BITS = 14;
    localparam int POS_TOP  = (1 << POS_BITS) - 1;
    localparam int DLY_BITS = spmb_pkg::DELAY_BITS;
    localparam int IN_W     = ((POS_BITS + DLY_BITS + 7) / 8) * 8;
    localparam int OUT_W    = ((spmb_pkg::COIL_BITS + POS_BITS + 2 + 7) / 8) * 8;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    typedef struct {
        logic                  cmd;
        logic [POS_BITS-1:0]   target;
        logic [DLY_BITS-1:0]   step_delay;
    } motion_word_t;

    typedef struct {
        logic [spmb_pkg::COIL_BITS-1:0] coils;
        logic                           busy;
        logic [POS_BITS-1:0]            position;
        logic                           ignored;
    } motor_status_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [spmb_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [spmb_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;   // target, step_delay, zero fill
    logic             s_axis_tuser  = 1'b0; // command
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // coils, busy_res, position, move_ignored, zero fill

    stepper_position_mover_backlash_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // mover model state
    logic [POS_BITS-1:0]                lim_lo   = '0;
    logic [POS_BITS-1:0]                lim_hi   = POS_BITS'(POS_TOP);
    logic [spmb_pkg::BACKLASH_BITS-1:0] bl_cfg   = '0;
    logic [spmb_pkg::TABLE_BITS-1:0]    coil_map = '0;

    logic [POS_BITS:0]                  pos_lp     = (POS_BITS+1)'(POS_TOP);
    logic [2:0]                         phase_ix   = '0;
    spmb_pkg::dir_t                     last_dir   = spmb_pkg::DIR_NONE;
    spmb_pkg::dir_t                     mv_dir     = spmb_pkg::DIR_NONE;
    logic [POS_BITS-1:0]                mv_target  = '0;
    logic [DLY_BITS-1:0]                hold_cnt   = '0;
    logic [DLY_BITS-1:0]                hold_len   = '0;
    logic [spmb_pkg::BACKLASH_BITS-1:0] bl_left    = '0;
    spmb_pkg::stage_t                   mv_stage   = spmb_pkg::ST_IDLE;
    logic                               from_limit = 1'b0;

    motion_word_t  word_backlog[$];
    motor_status_t expected_status[$];
    motion_word_t  cur_word;

    int words_pushed = 0;
    int words_taken  = 0;
    int results_seen = 0;
    int errors       = 0;

    bit word_taken   = 1'b0;
    bit result_taken = 1'b0;
    int tx_pause     = 0;
    int tx_calm      = 0;
    int rx_pause     = 0;
    int rx_calm      = 0;
    int holdoff      = 0;
    bit holdoff_done = 1'b0;

    // stimulus-side guess of where the motor will be
    int             est_pos;
    spmb_pkg::dir_t est_dir;
    int             gen_lo;
    int             gen_hi;
    int             gen_bl;
    int             max_dly;
    bit             wide_targets;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // ---------------- model of the sequencer ----------------

    task automatic step_phase();
        if (mv_dir == spmb_pkg::DIR_UP)
            phase_ix = phase_ix + 3'd1;
        else if (mv_dir == spmb_pkg::DIR_DOWN)
            phase_ix = phase_ix - 3'd1;
    endtask

    task automatic nudge_position(input bit forward);
        bit up;
        if (mv_dir == spmb_pkg::DIR_NONE)
            return;
        up = (mv_dir == spmb_pkg::DIR_UP) ^ !forward;
        pos_lp = up ? pos_lp + 1'b1 : pos_lp - 1'b1;
    endtask

    task automatic begin_main();
        if (from_limit)
            nudge_position(1'b1);
        mv_stage = spmb_pkg::ST_MAIN_FIRST;
    endtask

    task automatic launch_move(input logic [POS_BITS-1:0] tgt, input logic [DLY_BITS-1:0] dly);
        logic [POS_BITS-1:0] t;
        bit reversal;
        t = tgt;
        if (t > lim_hi)
            t = lim_hi;
        if (t < lim_lo)
            t = lim_lo;
        mv_target = t;
        if (pos_lp < t)
            mv_dir = spmb_pkg::DIR_UP;
        else if (pos_lp > t)
            mv_dir = spmb_pkg::DIR_DOWN;
        else
            mv_dir = spmb_pkg::DIR_NONE;
        hold_len   = (dly != 0) ? dly : DLY_BITS'(1);
        hold_cnt   = hold_len;
        from_limit = (pos_lp == lim_hi) || (pos_lp == lim_lo);
        reversal   = (mv_dir == spmb_pkg::DIR_UP && last_dir == spmb_pkg::DIR_DOWN) ||
                     (mv_dir == spmb_pkg::DIR_DOWN && last_dir == spmb_pkg::DIR_UP);
        if (mv_dir != spmb_pkg::DIR_NONE)
            last_dir = mv_dir;
        if (reversal)
        begin
            bl_left  = bl_cfg;
            mv_stage = spmb_pkg::ST_BL_FIRST;
        end
        else
            begin_main();
    endtask

    task automatic next_pattern();
        hold_cnt = hold_len;
        if (mv_stage == spmb_pkg::ST_BL_FIRST || mv_stage == spmb_pkg::ST_BL_STEP)
        begin
            if (bl_left > 0)
            begin
                step_phase();
                bl_left  = bl_left - 1'b1;
                mv_stage = spmb_pkg::ST_BL_STEP;
            end
            else
                begin_main();
            return;
        end
        if (mv_dir != spmb_pkg::DIR_NONE && pos_lp != mv_target &&
            pos_lp < lim_hi && pos_lp > lim_lo)
        begin
            step_phase();
            nudge_position(1'b1);
            mv_stage = spmb_pkg::ST_WALK;
            return;
        end
        // give back the step taken when the move began on a limit
        if (from_limit)
            nudge_position(1'b0);
        mv_stage = spmb_pkg::ST_IDLE;
        hold_cnt = '0;
    endtask

    task automatic predict_status(input motion_word_t w);
        motor_status_t st;
        st.ignored = 1'b0;
        if (w.cmd == CMD_MOVE && mv_stage == spmb_pkg::ST_IDLE)
            launch_move(w.target, w.step_delay);
        else
        begin
            if (w.cmd == CMD_MOVE)
                st.ignored = 1'b1;
            if (mv_stage != spmb_pkg::ST_IDLE)
            begin
                if (hold_cnt > 1)
                    hold_cnt = hold_cnt - 1'b1;
                else
                    next_pattern();
            end
        end
        st.coils    = (mv_stage == spmb_pkg::ST_IDLE) ? '0 : coil_map[phase_ix*4 +: 4];
        st.busy     = (mv_stage != spmb_pkg::ST_IDLE);
        st.position = (pos_lp > POS_TOP) ? POS_TOP[POS_BITS-1:0] : pos_lp[POS_BITS-1:0];
        expected_status.push_back(st);
    endtask

    // ---------------- sender and receiver ----------------

    function automatic int pick_pause(ref int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_status(cur_word);
            word_taken = 1'b1;
            words_taken++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || word_taken))
        begin
            word_taken = 1'b0;
            if (tx_pause > 0)
            begin
                tx_pause--;
                s_axis_tvalid <= 1'b0;
            end
            else if (word_backlog.size() > 0)
            begin
                cur_word = word_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= cur_word.cmd;
                s_axis_tdata  <= {{(IN_W-POS_BITS-DLY_BITS){1'b0}},
                                  cur_word.step_delay, cur_word.target};
                tx_pause = pick_pause(tx_calm);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        motor_status_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_taken = 1'b1;
            results_seen++;
            if (expected_status.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected word: expected none, actual %h", $time, m_axis_tdata);
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("coils", want.coils, m_axis_tdata[3:0]);
                check_field("busy_res", want.busy, m_axis_tdata[4]);
                check_field("position", want.position, m_axis_tdata[18:5]);
                check_field("move_ignored", want.ignored, m_axis_tdata[19]);
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // starve the output once so the command queue fills and input backs up
            if (!holdoff_done && results_seen >= 250 && word_backlog.size() > 16)
            begin
                holdoff      = 180;
                holdoff_done = 1'b1;
            end
            if (holdoff > 0)
            begin
                holdoff--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (result_taken)
                    rx_pause = pick_pause(rx_calm);
                result_taken = 1'b0;
                if (rx_pause > 0)
                begin
                    rx_pause--;
                    m_axis_tready <= 1'b0;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic int clamp_pos(input int v);
        return (v < 0) ? 0 : (v > POS_TOP) ? POS_TOP : v;
    endfunction

    task automatic push_word(input logic cmd, input int tgt, input int dly);
        motion_word_t w;
        w.cmd        = cmd;
        w.target     = POS_BITS'(tgt);
        w.step_delay = DLY_BITS'(dly);
        word_backlog.push_back(w);
        words_pushed++;
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++)
            push_word(CMD_TICK, $urandom, $urandom);
    endtask

    task automatic cfg_write(input logic [spmb_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [spmb_pkg::CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            spmb_pkg::REG_POSITION_MIN: lim_lo   = val[POS_BITS-1:0];
            spmb_pkg::REG_POSITION_MAX: lim_hi   = val[POS_BITS-1:0];
            spmb_pkg::REG_BACKLASH:     bl_cfg   = val[spmb_pkg::BACKLASH_BITS-1:0];
            spmb_pkg::REG_COIL_TABLE:   coil_map = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (words_taken == words_pushed && expected_status.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic add_move_episode();
        int d;
        int off;
        int r;
        int tgt;
        int t_eff;
        int span;
        int ticks;
        spmb_pkg::dir_t dir;
        bit rev;
        d   = $urandom_range(0, max_dly);
        off = $urandom_range(0, 24);
        r   = $urandom_range(0, 99);
        if (r < 8)
            tgt = est_pos;
        else if (r < 16 && wide_targets)
            tgt = $urandom_range(0, 1) ? POS_TOP : 0;
        else
            tgt = clamp_pos(est_pos + off - 12);
        push_word(CMD_MOVE, tgt, d);
        // the word right after a move always lands while busy: full-range noise
        if ($urandom_range(0, 4) == 0)
            push_word(CMD_MOVE, $urandom, $urandom);
        t_eff = (tgt > gen_hi) ? gen_hi : tgt;
        if (t_eff < gen_lo)
            t_eff = gen_lo;
        dir = (t_eff > est_pos) ? spmb_pkg::DIR_UP :
              (t_eff < est_pos) ? spmb_pkg::DIR_DOWN : spmb_pkg::DIR_NONE;
        rev = (dir == spmb_pkg::DIR_UP && est_dir == spmb_pkg::DIR_DOWN) ||
              (dir == spmb_pkg::DIR_DOWN && est_dir == spmb_pkg::DIR_UP);
        if (dir != spmb_pkg::DIR_NONE)
            est_dir = dir;
        span  = (t_eff > est_pos) ? t_eff - est_pos : est_pos - t_eff;
        ticks = (span + (rev ? gen_bl : 0) + 3) * ((d == 0) ? 1 : d);
        // cut some moves short so the next request arrives while busy
        if ($urandom_range(0, 6) == 0)
            ticks = ticks / 2;
        else
            ticks += $urandom_range(0, 3);
        push_ticks(ticks);
        est_pos = t_eff;
    endtask

    task automatic run_phase(input int lo, input int hi, input int bl, input logic [31:0] tbl,
                             input int dly_top, input bit wide, input int quota);
        int stop_at;
        cfg_write(spmb_pkg::REG_POSITION_MIN, lo);
        cfg_write(spmb_pkg::REG_POSITION_MAX, hi);
        cfg_write(spmb_pkg::REG_BACKLASH, bl);
        cfg_write(spmb_pkg::REG_COIL_TABLE, tbl);
        gen_lo       = lo;
        gen_hi       = hi;
        gen_bl       = bl;
        max_dly      = dly_top;
        wide_targets = wide;
        est_pos      = (pos_lp > POS_TOP) ? POS_TOP : pos_lp;
        est_dir      = last_dir;
        stop_at      = words_pushed + quota;
        while (words_pushed < stop_at)
            add_move_episode();
        drain();
    endtask

    initial
    begin
        int p;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cfg_write(spmb_pkg::REG_COIL_TABLE, 32'h9A5C_3618);
        cfg_write(spmb_pkg::REG_BACKLASH, 3);
        cfg_write(spmb_pkg::REG_POSITION_MIN, 0);
        cfg_write(spmb_pkg::REG_POSITION_MAX, POS_TOP);

        // tick while idle, move to where it already is (on the upper limit)
        push_word(CMD_TICK, 0, 0);
        push_word(CMD_MOVE, POS_TOP, 0);
        push_ticks(2);
        // walk down from the limit with zero delay, then a dropped move
        push_word(CMD_MOVE, POS_TOP - 4, 0);
        push_word(CMD_MOVE, 0, 16'hFFFF);
        push_word(CMD_TICK, 14'h3FFF, 16'hFFFF);
        push_ticks(5);
        // reverse upward: backlash take-up first
        push_word(CMD_MOVE, POS_TOP, 1);
        push_word(CMD_TICK, 14'h3FFF, 16'hFFFF);
        push_ticks(11);
        drain();

        run_phase(0, POS_TOP, 0, $urandom, 4, 1'b0, 150);
        p = (pos_lp > POS_TOP) ? POS_TOP : pos_lp;
        run_phase(clamp_pos(p - 25), clamp_pos(p + 25), $urandom_range(1, 6), $urandom,
                  5, 1'b1, 200);
        p = (pos_lp > POS_TOP) ? POS_TOP : pos_lp;
        run_phase(p, p, 2, $urandom, 3, 1'b1, 60);
        p = (pos_lp > POS_TOP) ? POS_TOP : pos_lp;
        // crossed limits: every target collapses onto the lower bound
        run_phase(clamp_pos(p + 4), clamp_pos(p - 4), 1, 32'hFFFF_FFFF, 3, 1'b1, 60);
        p = (pos_lp > POS_TOP) ? POS_TOP : pos_lp;
        run_phase(p, clamp_pos(p + 30), 255, $urandom, 1, 1'b1, 120);
        p = (pos_lp > POS_TOP) ? POS_TOP : pos_lp;
        run_phase(0, clamp_pos(p + 15), $urandom_range(0, 15), 32'h0, 4, 1'b0, 150);

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
